// ===== rtl/bpd_pkg.sv =====
package bpd_pkg;

    localparam int HISTORY_DEPTH_DEF = 512;
    localparam int SIGN_BIAS_DEF     = 6554;

    localparam logic signed [47:0] MAX48 = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] MIN48 = 48'sh8000_0000_0000;
    localparam logic signed [63:0] PID_LIMIT = 64'sd19660800000;
    localparam logic signed [63:0] TERM_MAX  = 64'sd2305843009213693952;
    localparam logic [16:0] DERIV_TAU_Q = 17'd1311;

    typedef enum logic [2:0] {
        ACT_SAMPLE    = 3'd0,
        ACT_FWD_PRESS = 3'd1,
        ACT_FWD_REL   = 3'd2,
        ACT_BWD_PRESS = 3'd3,
        ACT_BWD_REL   = 3'd4
    } action_t;

    typedef enum logic [2:0] {
        REG_KP     = 3'd0,
        REG_KI     = 3'd1,
        REG_KD     = 3'd2,
        REG_STEP   = 3'd3,
        REG_SMOOTH = 3'd4,
        REG_DECAY  = 3'd5,
        REG_DRIFT  = 3'd6,
        REG_WINDOW = 3'd7
    } reg_index_t;

    // Saturate a 64-bit value to the signed 48-bit range.
    function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
        if (v > 64'(MAX48))
            return MAX48;
        else if (v < 64'(MIN48))
            return MIN48;
        else
            return v[47:0];
    endfunction

    function automatic logic signed [63:0] clamp64(input logic signed [63:0] v,
                                                   input logic signed [63:0] lim);
        if (v > lim)
            return lim;
        else if (v < -lim)
            return -lim;
        else
            return v;
    endfunction

endpackage

// ===== rtl/bpd_ram.sv =====
module bpd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/bpd_divider.sv =====
// Signed restoring divider, one quotient bit per cycle, truncating toward zero.
module bpd_divider (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [63:0] dividend,
    input  logic        [31:0] divisor,
    output logic               done,
    output logic signed [63:0] quotient
);

    logic [63:0] quo_reg, quo_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] den_reg;
    logic        neg_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic [32:0] trial;

    always_comb
    begin
        trial    = {rem_reg[31:0], quo_reg[63]};
        quo_next = {quo_reg[62:0], 1'b0};
        rem_next = trial;
        if (trial >= {1'b0, den_reg})
        begin
            rem_next    = trial - {1'b0, den_reg};
            quo_next[0] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd64;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend[63] ? 64'(-dividend) : dividend;
            rem_reg <= '0;
            den_reg <= divisor;
            neg_reg <= dividend[63];
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);

endmodule

// ===== rtl/balance_pid_drive_controller_unit.sv =====
// Channel   | Direction | Handshake            | Payload
// s_axis    | in        | tvalid/tready        | tdata: tilt, accel, time step; tuser: action
// m_axis    | out       | tvalid/tready        | tdata: drive_out, pid_clipped
// cfg       | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// A sample occupies the block until its result is stored: four runs of the shared serial
// divider (window average, raw derivative, derivative filter gain, smoothing gain) and
// single-step states in between make up its path. Button events produce no transfer.
// Reset clears all controller state; the window RAM needs no clearing since only
// written entries are read. A result waits in the output register while the next item
// is taken; a sample that finishes while that register is still full stalls there.
module balance_pid_drive_controller_unit #(
    parameter int HISTORY_DEPTH = bpd_pkg::HISTORY_DEPTH_DEF,
    parameter int SIGN_BIAS     = bpd_pkg::SIGN_BIAS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [31:0] tilt_angle, [63:32] accel_fwd, [80:64] time_step, [87:81] zero
    input  logic [87:0] s_axis_tdata,
    // [2:0] action
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [47:0] drive_out, [48] pid_clipped, [55:49] zero
    output logic [55:0] m_axis_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import bpd_pkg::*;

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int CW = AW + 1;

    typedef enum logic [4:0] {
        ST_IDLE, ST_EVENT, ST_RDOLD, ST_WIN, ST_AVG, ST_AVGW, ST_BIAS, ST_DECAY,
        ST_DRAW, ST_DRAWW, ST_ALPHA, ST_ALPHAW, ST_FILT, ST_INTEG,
        ST_TP, ST_TI, ST_TD, ST_SUM, ST_KDIV, ST_KDIVW, ST_SMOOTH, ST_OUT
    } state_t;

    state_t state_reg;

    logic signed [31:0] kp_reg, ki_reg, kd_reg, step_reg, drift_reg;
    logic [30:0] smooth_reg, decay_reg;
    logic [9:0]  win_len_reg;

    logic signed [47:0] integ_reg, filt_reg, bias_reg, smoothed_reg;
    logic signed [31:0] last_err_reg;
    logic               manual_reg;
    logic [CW-1:0]      count_reg;
    logic [AW-1:0]      head_reg;
    logic signed [47:0] hsum_reg;

    logic [2:0]         act_reg;
    logic signed [31:0] e_reg, accel_reg;
    logic [16:0]        dt_reg;
    logic signed [63:0] avg_reg, draw_reg, alpha_reg, tp_reg, ti_reg, u_reg;
    logic signed [63:0] prod_reg;
    logic               clip_reg;
    logic               out_valid_reg;
    logic [47:0]        out_drive_reg;
    logic               out_clip_reg;

    // divider
    logic               div_start;
    logic signed [63:0] div_dividend;
    logic [31:0]        div_divisor;
    logic               div_done;
    logic signed [63:0] div_q;

    bpd_divider u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dividend),
        .divisor(div_divisor), .done(div_done), .quotient(div_q)
    );

    // history RAM
    logic          ram_we;
    logic [AW-1:0] ram_raddr;
    logic [31:0]   ram_rdata;
    logic [CW-1:0] win_eff;

    bpd_ram #(.WIDTH(32), .DEPTH(HISTORY_DEPTH)) u_hist (
        .clk(clk), .we(ram_we), .waddr(head_reg), .wdata(accel_reg),
        .raddr(ram_raddr), .rdata(ram_rdata)
    );

    always_comb
    begin
        if (win_len_reg == 10'd0)
            win_eff = CW'(1);
        else if (32'(win_len_reg) > HISTORY_DEPTH)
            win_eff = CW'(HISTORY_DEPTH);
        else
            win_eff = CW'(win_len_reg);
    end

    assign ram_raddr = head_reg - count_reg[AW-1:0];
    assign ram_we    = (state_reg == ST_WIN);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_clip_reg, out_drive_reg};

    // floor(a*b/2^16) for a within 50 signed bits: the high part a[49:16] times b
    // plus the floored product of the unsigned low 16 bits.
    function automatic logic signed [63:0] mulq(input logic signed [63:0] a,
                                                input logic signed [31:0] b);
        logic signed [33:0] hi;
        logic signed [16:0] lo;
        logic signed [65:0] hp;
        logic signed [48:0] lp;
        hi = $signed(a[49:16]);
        lo = $signed({1'b0, a[15:0]});
        hp = hi * b;
        lp = lo * b;
        return 64'(hp) + 64'(lp >>> 16);
    endfunction

    logic signed [63:0] dec_w, mag_w, sum_w, ediff_w;
    assign dec_w = (64'(decay_reg) * 64'(dt_reg)) >>> 16;
    assign mag_w = bias_reg[47] ? -64'(bias_reg) : 64'(bias_reg);

    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = 32'd1;
        ediff_w      = 64'(e_reg) - 64'(last_err_reg);
        case (state_reg)
            ST_AVG:
            begin
                div_start    = 1'b1;
                div_dividend = 64'(hsum_reg);
                div_divisor  = 32'(count_reg);
            end
            ST_DRAW:
            begin
                div_start    = 1'b1;
                div_dividend = ediff_w <<< 16;
                div_divisor  = 32'(dt_reg);
            end
            ST_ALPHA:
            begin
                div_start    = 1'b1;
                div_dividend = 64'(dt_reg) <<< 16;
                div_divisor  = 32'(dt_reg) + 32'(DERIV_TAU_Q);
            end
            ST_KDIV:
            begin
                div_start    = 1'b1;
                div_dividend = 64'(dt_reg) <<< 16;
                div_divisor  = (smooth_reg == 31'd0) ? 32'd1 : 32'(smooth_reg);
            end
            default: ;
        endcase
    end

    assign sum_w = tp_reg + ti_reg + prod_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg      <= 32'sd1966080;
            ki_reg      <= 32'sd655360;
            kd_reg      <= 32'sd32768;
            step_reg    <= 32'sd26214;
            smooth_reg  <= 31'd262144;
            decay_reg   <= 31'd3277;
            drift_reg   <= -32'sd26214;
            win_len_reg <= 10'd500;
        end
        else if (cfg_valid)
        begin
            case (reg_index_t'(cfg_index))
                REG_KP:     kp_reg      <= cfg_data;
                REG_KI:     ki_reg      <= cfg_data;
                REG_KD:     kd_reg      <= cfg_data;
                REG_STEP:   step_reg    <= cfg_data;
                REG_SMOOTH: smooth_reg  <= cfg_data[30:0];
                REG_DECAY:  decay_reg   <= cfg_data[30:0];
                REG_DRIFT:  drift_reg   <= cfg_data;
                REG_WINDOW: win_len_reg <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            integ_reg     <= '0;
            filt_reg      <= '0;
            bias_reg      <= '0;
            smoothed_reg  <= '0;
            last_err_reg  <= '0;
            manual_reg    <= 1'b0;
            count_reg     <= '0;
            head_reg      <= '0;
            hsum_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && m_axis_tready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid && s_axis_tready)
                    begin
                        act_reg   <= s_axis_tuser;
                        e_reg     <= s_axis_tdata[31:0];
                        accel_reg <= s_axis_tdata[63:32];
                        dt_reg    <= s_axis_tdata[80:64];
                        state_reg <= (s_axis_tuser == ACT_SAMPLE) ? ST_RDOLD : ST_EVENT;
                    end
                end
                ST_EVENT:
                begin
                    case (act_reg)
                        ACT_FWD_PRESS:
                        begin
                            manual_reg <= 1'b1;
                            bias_reg   <= sat48(64'(bias_reg) + 64'(step_reg));
                        end
                        ACT_BWD_PRESS:
                        begin
                            manual_reg <= 1'b1;
                            bias_reg   <= sat48(64'(bias_reg) - 64'(step_reg));
                        end
                        ACT_FWD_REL, ACT_BWD_REL: manual_reg <= 1'b0;
                        default: ;
                    endcase
                    state_reg <= ST_IDLE;
                end
                ST_RDOLD: state_reg <= ST_WIN;   // RAM read of the oldest entry
                ST_WIN:
                begin
                    if (count_reg >= win_eff)
                    begin
                        hsum_reg  <= hsum_reg - 48'(signed'(ram_rdata)) +
                                     48'(accel_reg);
                    end
                    else
                    begin
                        hsum_reg  <= hsum_reg + 48'(accel_reg);
                        count_reg <= count_reg + CW'(1);
                    end
                    head_reg  <= head_reg + AW'(1);
                    state_reg <= ST_AVG;
                end
                ST_AVG:  state_reg <= ST_AVGW;
                ST_AVGW:
                begin
                    if (div_done)
                    begin
                        avg_reg   <= div_q;
                        state_reg <= ST_BIAS;
                    end
                end
                ST_BIAS:
                begin
                    if (!manual_reg)
                        bias_reg <= 48'(-mulq(avg_reg, drift_reg));
                    state_reg <= ST_DECAY;
                end
                ST_DECAY:
                begin
                    if (bias_reg != 48'sd0)
                    begin
                        if (mag_w > dec_w)
                            bias_reg <= bias_reg[47] ? 48'(64'(bias_reg) + dec_w)
                                                     : 48'(64'(bias_reg) - dec_w);
                        else
                            bias_reg <= bias_reg[47] ? 48'(dec_w - mag_w)
                                                     : 48'(mag_w - dec_w);
                    end
                    state_reg <= ST_DRAW;
                end
                ST_DRAW: state_reg <= ST_DRAWW;
                ST_DRAWW:
                begin
                    if (div_done)
                    begin
                        draw_reg  <= (dt_reg == 17'd0) ? 64'sd0 : 64'(sat48(div_q));
                        state_reg <= ST_ALPHA;
                    end
                end
                ST_ALPHA: state_reg <= ST_ALPHAW;
                ST_ALPHAW:
                begin
                    if (div_done)
                    begin
                        alpha_reg <= div_q;
                        state_reg <= ST_FILT;
                    end
                end
                ST_FILT:
                begin
                    filt_reg  <= 48'(64'(filt_reg) +
                                 mulq(draw_reg - 64'(filt_reg), alpha_reg[31:0]));
                    state_reg <= ST_INTEG;
                end
                ST_INTEG:
                begin
                    if (64'(smoothed_reg) > -PID_LIMIT && 64'(smoothed_reg) < PID_LIMIT)
                        integ_reg <= sat48(64'(integ_reg) +
                                     ((64'(e_reg) * $signed(64'(dt_reg))) >>> 16));
                    state_reg <= ST_TP;
                end
                ST_TP:
                begin
                    tp_reg    <= clamp64(mulq(64'(e_reg), kp_reg), TERM_MAX);
                    state_reg <= ST_TI;
                end
                ST_TI:
                begin
                    ti_reg    <= clamp64(mulq(64'(integ_reg), ki_reg), TERM_MAX);
                    state_reg <= ST_TD;
                end
                ST_TD:
                begin
                    prod_reg  <= clamp64(mulq(64'(filt_reg), kd_reg), TERM_MAX) +
                                 ((e_reg > 0) ? 64'(SIGN_BIAS) : -64'(SIGN_BIAS));
                    state_reg <= ST_SUM;
                end
                ST_SUM:
                begin
                    clip_reg     <= (sum_w > PID_LIMIT) || (sum_w < -PID_LIMIT);
                    u_reg        <= clamp64(sum_w, PID_LIMIT) + 64'(bias_reg);
                    last_err_reg <= e_reg;
                    state_reg    <= ST_KDIV;
                end
                ST_KDIV: state_reg <= ST_KDIVW;
                ST_KDIVW:
                begin
                    if (div_done)
                    begin
                        alpha_reg <= (div_q > 64'sd1073741824) ? 64'sd1073741824 : div_q;
                        state_reg <= ST_SMOOTH;
                    end
                end
                ST_SMOOTH:
                begin
                    smoothed_reg <= sat48(64'(smoothed_reg) +
                                    mulq(u_reg - 64'(smoothed_reg), alpha_reg[31:0]));
                    state_reg    <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (!out_valid_reg)
                    begin
                        out_valid_reg <= 1'b1;
                        out_drive_reg <= smoothed_reg;
                        out_clip_reg  <= clip_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(HISTORY_DEPTH)) else $error("window count overflow");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_axis_tready |=> $stable(out_drive_reg))
        else $error("result changed while stalled");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> !s_axis_tready) else $error("accept while busy");
`endif

endmodule

// ===== dv/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bpd_pkg::*;

    // Upper bound on the whole run. With heavy stalls on both sides and the
    // long hold-off this is still several times the slowest correct run.
    localparam int CYCLE_LIMIT = 2_000_000;

    // Cycles to let pass after the last expected result before a register
    // write or the end of the run. An event produces no transfer, so the block
    // may still be busy with one when the queue runs empty.
    localparam int SETTLE_CYCLES = 300;

    localparam int WIN_DEPTH = 512;
    localparam longint SAT_HI = 64'sd140737488355327;
    localparam longint SAT_LO = -64'sd140737488355328;
    localparam longint PID_LIM = 64'sd19660800000;
    localparam longint TERM_LIM = 64'sd2305843009213693952;
    localparam longint GAIN_LIM = 64'sd1073741824;
    localparam longint TAU_DERIV = 64'sd1311;

    typedef struct {
        logic [47:0] drive;
        logic        clipped;
    } drive_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [87:0] s_axis_tdata;
    logic [2:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    balance_pid_drive_controller_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Expected drive results, oldest first.
    drive_result_t drive_expect_q[$];

    int     mismatch_count = 0;
    int     cycle_count = 0;
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    int     hold_off_left = 0;

    // Shadow copy of the configuration registers. Signed fields are kept sign
    // extended, the smoothing constant and decay rate as plain unsigned values.
    longint gain_p, gain_i, gain_d, press_step, smooth_tau, decay_per_s, drift_scale;
    int     window_len;

    // Shadow copy of the controller state.
    longint integ, prev_err, deriv_filt, bias, drive_smooth, accel_sum;
    bit     manual;
    longint accel_hist[WIN_DEPTH];
    int     hist_count, hist_head;

    // Clock with a 4 ns period.
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Cycle counter and the hard stop when the run hangs.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver side: ready changes on the falling edge. A pending hold-off
    // keeps ready low for its full count, which lets the output register fill
    // and the block stall its input. Otherwise ready stalls at random if a stall percentage is set.
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_left > 0)
            begin
                m_axis_tready = 1'b0;
                hold_off_left--;
            end
            else if (recv_stall_pct > 0)
                m_axis_tready = ($urandom_range(0, 99) >= recv_stall_pct);
            else
                m_axis_tready = 1'b1;
        end
    end

    task automatic report_mismatch(input string what);
        $display("tb: mismatch at cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    // Result checker: every output transfer is matched with the oldest
    // expectation, field by field.
    always @(posedge clk)
    begin
        drive_result_t exp_res;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (drive_expect_q.size() == 0)
                report_mismatch($sformatf("unexpected result %h", m_axis_tdata));
            else
            begin
                exp_res = drive_expect_q[0];
                drive_expect_q.delete(0);
                if (m_axis_tdata[47:0] !== exp_res.drive)
                    report_mismatch($sformatf("drive_out got %h expected %h",
                                              m_axis_tdata[47:0], exp_res.drive));
                if (m_axis_tdata[48] !== exp_res.clipped)
                    report_mismatch($sformatf("pid_clipped got %b expected %b",
                                              m_axis_tdata[48], exp_res.clipped));
            end
        end
    end

    function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Fixed-point product floor(a*b / 2^16), split so the partial products
    // stay inside 64 bits for a up to about 2^48 and b up to 2^31.
    function automatic longint q16_mul(input longint a, input longint b);
        longint hi_part;
        longint lo_part;
        hi_part = a >>> 16;
        lo_part = a - hi_part * 65536;
        return hi_part * b + ((lo_part * b) >>> 16);
    endfunction

    function automatic void load_default_regs();
        gain_p      = 1966080;
        gain_i      = 655360;
        gain_d      = 32768;
        press_step  = 26214;
        smooth_tau  = 262144;
        decay_per_s = 3277;
        drift_scale = -26214;
        window_len  = 500;
    endfunction

    function automatic void clear_controller();
        integ        = 0;
        prev_err     = 0;
        deriv_filt   = 0;
        bias         = 0;
        drive_smooth = 0;
        accel_sum    = 0;
        manual       = 1'b0;
        hist_count   = 0;
        hist_head    = 0;
        foreach (accel_hist[i])
            accel_hist[i] = 0;
    endfunction

    function automatic void update_reg(input logic [2:0] idx, input logic [31:0] value);
        case (reg_index_t'(idx))
            REG_KP:     gain_p      = longint'($signed(value));
            REG_KI:     gain_i      = longint'($signed(value));
            REG_KD:     gain_d      = longint'($signed(value));
            REG_STEP:   press_step  = longint'($signed(value));
            REG_SMOOTH: smooth_tau  = longint'({33'd0, value[30:0]});
            REG_DECAY:  decay_per_s = longint'({33'd0, value[30:0]});
            REG_DRIFT:  drift_scale = longint'($signed(value));
            REG_WINDOW: window_len  = int'(value[9:0]);
            default: ;
        endcase
    endfunction

    // Advance the shadow controller by one input item. Returns 1 and fills
    // res when the item is a sample, which is the only kind with a result.
    function automatic bit controller_step(input logic [2:0] act, input logic [31:0] tilt,
                                           input logic [31:0] accel_in,
                                           input logic [16:0] step_in,
                                           output drive_result_t res);
        longint err, accel, dt, avg, dec, mag, alpha, d_raw, pid, target, k, tau;
        longint t_p, t_i, t_d;
        int     win, oldest;
        bit     clip;
        res.drive = '0;
        res.clipped = 1'b0;
        if (act != ACT_SAMPLE)
        begin
            // Presses enter manual mode and nudge the bias, releases leave it.
            // Codes beyond the last action are ignored.
            case (act)
                ACT_FWD_PRESS:
                begin
                    manual = 1'b1;
                    bias = clamp_to(bias + press_step, SAT_LO, SAT_HI);
                end
                ACT_BWD_PRESS:
                begin
                    manual = 1'b1;
                    bias = clamp_to(bias - press_step, SAT_LO, SAT_HI);
                end
                ACT_FWD_REL, ACT_BWD_REL: manual = 1'b0;
                default: ;
            endcase
            return 1'b0;
        end

        err   = longint'($signed(tilt));
        accel = longint'($signed(accel_in));
        dt    = longint'({47'd0, step_in});

        // Moving average: at most one old entry leaves per sample, so a
        // shrunken window keeps the entry count it already holds.
        win = (window_len == 0) ? 1 : ((window_len > WIN_DEPTH) ? WIN_DEPTH : window_len);
        if (hist_count >= win)
        begin
            oldest = (hist_head + WIN_DEPTH - hist_count) % WIN_DEPTH;
            accel_sum -= accel_hist[oldest];
            hist_count--;
        end
        accel_hist[hist_head] = accel;
        accel_sum += accel;
        hist_count++;
        hist_head = (hist_head + 1) % WIN_DEPTH;
        avg = accel_sum / longint'(hist_count);

        // Drift bias, then decay toward zero; the decay may carry it across.
        if (!manual)
            bias = -q16_mul(avg, drift_scale);
        dec = (decay_per_s * dt) >>> 16;
        if (bias != 0)
        begin
            mag = (bias < 0) ? -bias : bias;
            if (mag > dec)
                bias += (bias > 0) ? -dec : dec;
            else
                bias = (bias > 0) ? -(dec - mag) : (dec - mag);
        end

        // Filtered derivative; a zero time step leaves it unchanged.
        d_raw = (dt > 0) ? clamp_to(((err - prev_err) * 65536) / dt, SAT_LO, SAT_HI) : 0;
        alpha = (dt * 65536) / (TAU_DERIV + dt);
        deriv_filt += q16_mul(d_raw - deriv_filt, alpha);

        // Anti-windup: integrate only while the previous output is in range.
        if (drive_smooth > -PID_LIM && drive_smooth < PID_LIM)
            integ = clamp_to(integ + ((err * dt) >>> 16), SAT_LO, SAT_HI);

        t_p = clamp_to(q16_mul(err, gain_p), -TERM_LIM, TERM_LIM);
        t_i = clamp_to(q16_mul(integ, gain_i), -TERM_LIM, TERM_LIM);
        t_d = clamp_to(q16_mul(deriv_filt, gain_d), -TERM_LIM, TERM_LIM);
        pid = t_p + t_i + t_d + ((err > 0) ? longint'(SIGN_BIAS_DEF)
                                           : -longint'(SIGN_BIAS_DEF));
        clip = (pid > PID_LIM) || (pid < -PID_LIM);
        pid = clamp_to(pid, -PID_LIM, PID_LIM);
        prev_err = err;

        // First-order smoothing; a zero time constant counts as one LSB.
        target = pid + bias;
        tau = (smooth_tau == 0) ? 1 : smooth_tau;
        k = clamp_to((dt * 65536) / tau, 0, GAIN_LIM);
        drive_smooth = clamp_to(drive_smooth + q16_mul(target - drive_smooth, k),
                                SAT_LO, SAT_HI);

        res.drive = drive_smooth[47:0];
        res.clipped = clip;
        return 1'b1;
    endfunction

    // Offer one item on the input stream and wait for its transfer. The
    // sender may idle for a random number of cycles first.
    task automatic send_item(input logic [2:0] act, input logic [31:0] tilt,
                             input logic [31:0] accel, input logic [16:0] dt);
        drive_result_t res;
        @(negedge clk);
        while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tdata  = {7'd0, dt, accel, tilt};
        s_axis_tuser  = act;
        s_axis_tvalid = 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (controller_step(act, tilt, accel, dt, res))
            drive_expect_q.insert(drive_expect_q.size(), res);
    endtask

    task automatic stop_sending();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
    endtask

    // Wait until every expected result has arrived and the block is idle.
    task automatic drain_results();
        stop_sending();
        while (drive_expect_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Register write; only called while the block is idle.
    task automatic write_reg(input reg_index_t idx, input logic [31:0] value);
        @(negedge clk);
        cfg_index = idx;
        cfg_data  = value;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        update_reg(idx, value);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Q16.16 value with a mix of magnitudes: mostly modest, sometimes any
    // 32-bit pattern, sometimes the extremes.
    function automatic logic [31:0] rand_q16();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            return 32'($signed($urandom_range(0, 131072)) - 65536);
        else if (pick < 8)
            return $urandom;
        else if (pick == 8)
            return 32'h7FFF_FFFF;
        else
            return 32'h8000_0000;
    endfunction

    function automatic logic [16:0] rand_dt();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            return 17'd0;
        else if (pick == 1)
            return 17'd65536;
        else if (pick == 2)
            return 17'($urandom);
        else
            return 17'($urandom_range(1, 2000));
    endfunction

    // Random items: mostly samples, with button events and some unknown
    // action codes mixed in. Only samples count toward n.
    task automatic send_random(input int n);
        int sent;
        int pick;
        logic [2:0] act;
        sent = 0;
        while (sent < n)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 82)
                act = ACT_SAMPLE;
            else if (pick < 96)
                act = 3'($urandom_range(ACT_FWD_PRESS, ACT_BWD_REL));
            else
                act = 3'($urandom_range(5, 7));
            send_item(act, rand_q16(), rand_q16(), rand_dt());
            if (act == ACT_SAMPLE)
                sent++;
        end
    endtask

    // Directed items: field extremes, every action, zero time step, and the
    // unknown action codes.
    task automatic test_directed();
        send_item(ACT_SAMPLE, 32'd0, 32'd0, 17'd0);
        send_item(ACT_SAMPLE, 32'h0001_0000, 32'h0000_8000, 17'd66);
        send_item(ACT_SAMPLE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 17'd65536);
        send_item(ACT_SAMPLE, 32'h8000_0000, 32'h8000_0000, 17'h1FFFF);
        send_item(ACT_SAMPLE, 32'hFFFF_FFFF, 32'h0000_0001, 17'd1);
        send_item(ACT_SAMPLE, 32'h0000_0001, 32'hFFFF_FFFF, 17'd0);
        send_item(ACT_FWD_PRESS, 32'd0, 32'd0, 17'd0);
        send_item(ACT_SAMPLE, 32'h0000_4000, 32'd0, 17'd100);
        send_item(ACT_FWD_PRESS, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 17'h1FFFF);
        send_item(ACT_SAMPLE, 32'hFFFF_C000, 32'h0001_0000, 17'd100);
        send_item(ACT_FWD_REL, 32'd0, 32'd0, 17'd0);
        send_item(ACT_BWD_PRESS, 32'd0, 32'd0, 17'd0);
        send_item(ACT_SAMPLE, 32'd0, 32'hFFFF_0000, 17'd500);
        send_item(ACT_BWD_REL, 32'd0, 32'd0, 17'd0);
        send_item(3'd5, 32'h1234_5678, 32'h8765_4321, 17'd10);
        send_item(3'd6, 32'd0, 32'd0, 17'd0);
        send_item(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 17'h1FFFF);
        send_item(ACT_SAMPLE, 32'h0000_2000, 32'h0000_1000, 17'd2000);
        drain_results();
    endtask

    // Register sweep: each setting, extremes among them, followed by a burst
    // of random samples. Window lengths zero and beyond the store size hit
    // the clamping of the window.
    task automatic test_config_sweep();
        write_reg(REG_KP, 32'h7FFF_FFFF);
        write_reg(REG_KI, 32'h8000_0000);
        write_reg(REG_KD, 32'h7FFF_FFFF);
        write_reg(REG_STEP, 32'h8000_0000);
        write_reg(REG_SMOOTH, 32'd0);
        write_reg(REG_DECAY, 32'h7FFF_FFFF);
        write_reg(REG_DRIFT, 32'h8000_0000);
        write_reg(REG_WINDOW, 32'd0);
        send_random(15);
        drain_results();

        write_reg(REG_KP, 32'h8000_0000);
        write_reg(REG_KI, 32'h7FFF_FFFF);
        write_reg(REG_KD, 32'h8000_0000);
        write_reg(REG_STEP, 32'h7FFF_FFFF);
        write_reg(REG_SMOOTH, 32'hFFFF_FFFF);
        write_reg(REG_DECAY, 32'd0);
        write_reg(REG_DRIFT, 32'h7FFF_FFFF);
        write_reg(REG_WINDOW, 32'h3FF);
        send_random(15);
        drain_results();

        write_reg(REG_KP, 32'd0);
        write_reg(REG_KI, 32'd0);
        write_reg(REG_KD, 32'd0);
        write_reg(REG_SMOOTH, 32'd1);
        write_reg(REG_WINDOW, 32'd1);
        send_random(15);
        drain_results();

        // Long window first, then a short one; the window keeps the entries it
        // already holds, since one leaves for each that enters.
        write_reg(REG_KP, $urandom);
        write_reg(REG_KI, $urandom);
        write_reg(REG_KD, $urandom);
        write_reg(REG_STEP, $urandom);
        write_reg(REG_SMOOTH, $urandom);
        write_reg(REG_DECAY, $urandom_range(0, 65536));
        write_reg(REG_DRIFT, $urandom);
        write_reg(REG_WINDOW, 32'd16);
        send_random(15);
        drain_results();
        write_reg(REG_WINDOW, 32'd3);
        send_random(15);
        drain_results();

        // Back to values that keep the loop in its working range.
        write_reg(REG_KP, 32'd1966080);
        write_reg(REG_KI, 32'd655360);
        write_reg(REG_KD, 32'd32768);
        write_reg(REG_STEP, 32'd26214);
        write_reg(REG_SMOOTH, 32'd262144);
        write_reg(REG_DECAY, 32'd3277);
        write_reg(REG_DRIFT, 32'hFFFF_999A);
        write_reg(REG_WINDOW, 32'd512);
    endtask

    // Random traffic under one idling mix.
    task automatic test_idling(input int idle_pct, input int stall_pct, input int n);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        send_random(n);
        drain_results();
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering items, so the output register fills and the input stalls.
    // The sender then pauses until every expected result has come.
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off_left  = 2000;
        send_random(15);
        drain_results();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = ACT_SAMPLE;
        cfg_valid     = 1'b0;
        cfg_index     = REG_KP;
        cfg_data      = '0;
        load_default_regs();
        clear_controller();
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        test_directed();
        test_config_sweep();
        test_idling(0, 0, 70);
        test_idling(67, 0, 70);
        test_idling(0, 67, 70);
        test_idling(26, 26, 70);
        test_backpressure();

        drain_results();
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
